### rtl/anc_pkg.sv
// types and constants shared by the neighbor cache modules
`default_nettype none

package anc_pkg;

   localparam logic       OP_INSERT      = 1'b0;
   localparam logic       OP_LOOKUP      = 1'b1;
   localparam logic [31:0] LIFETIME_RESET = 32'd300000;
   localparam logic        REG_LIFETIME   = 1'b0;

   typedef struct packed {
      logic        op;
      logic [31:0] ip_addr;
      logic [47:0] mac_addr;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [47:0] mac_found;
      logic [2:0]  slot_used;
   } rsp_type;

   typedef struct packed {
      logic        active;
      logic        op;
      logic [31:0] ip_addr;
      logic [47:0] mac_addr;
      logic [63:0] now_ms;
      logic [63:0] expiry_new;
      logic        found;
      logic        free_found;
   } probe_type;

   typedef struct packed {
      logic        en;
      logic        fill;
      logic [31:0] ip_addr;
      logic [47:0] mac_addr;
      logic [63:0] expiry;
   } wr_type;

endpackage

`default_nettype wire

### rtl/anc_cell.sv
// one cache entry with its stage of the probe chain
`default_nettype none

module anc_cell #(
   parameter int IDX     = 0,
   parameter int IDX_W   = 3
) (
   input  wire                     clock,
   input  wire                     reset,
   input  anc_pkg::probe_type      probe_i,
   input  wire [IDX_W-1:0]         found_slot_i,
   input  wire [IDX_W-1:0]         free_slot_i,
   output anc_pkg::probe_type      probe_o,
   output logic [IDX_W-1:0]        found_slot_o,
   output logic [IDX_W-1:0]        free_slot_o,
   input  anc_pkg::wr_type         wr_i,
   input  wire [IDX_W-1:0]         wr_slot_i
);
   import anc_pkg::*;

   localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(IDX);

   logic              valid_ff, valid_in;
   logic [31:0]       ip_ff, ip_in;
   logic [47:0]       mac_ff, mac_in;
   logic [63:0]       expiry_ff, expiry_in;
   probe_type         probe_ff, probe_in;
   logic [IDX_W-1:0]  found_slot_ff, found_slot_in;
   logic [IDX_W-1:0]  free_slot_ff, free_slot_in;
   logic              expired;
   logic              ip_match;

   always_comb begin
      probe_in      = probe_i;
      found_slot_in = found_slot_i;
      free_slot_in  = free_slot_i;
      valid_in      = valid_ff;
      ip_in         = ip_ff;
      mac_in        = mac_ff;
      expiry_in     = expiry_ff;
      expired       = (expiry_ff <= probe_i.now_ms);
      ip_match      = (ip_ff == probe_i.ip_addr);
      if (probe_i.active) begin
         if (probe_i.op == OP_INSERT) begin
            if (!probe_i.found && valid_ff && ip_match) begin
               probe_in.found = 1'b1;
               found_slot_in  = MY_SLOT;
            end
            if (!probe_i.free_found && (!valid_ff || expired)) begin
               probe_in.free_found = 1'b1;
               free_slot_in        = MY_SLOT;
            end
         end else if (!probe_i.found && valid_ff) begin
            if (expired) begin
               valid_in = 1'b0;
            end else if (ip_match) begin
               probe_in.found    = 1'b1;
               probe_in.mac_addr = mac_ff;
               found_slot_in     = MY_SLOT;
            end
         end
      end
      if (wr_i.en && (wr_slot_i == MY_SLOT)) begin
         mac_in    = wr_i.mac_addr;
         expiry_in = wr_i.expiry;
         if (wr_i.fill) begin
            valid_in = 1'b1;
            ip_in    = wr_i.ip_addr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      ip_ff               <= ip_in;
      mac_ff              <= mac_in;
      expiry_ff           <= expiry_in;
      found_slot_ff       <= found_slot_in;
      free_slot_ff        <= free_slot_in;
   end

   assign probe_o      = probe_ff;
   assign found_slot_o = found_slot_ff;
   assign free_slot_o  = free_slot_ff;

endmodule

`default_nettype wire

### rtl/arp_neighbor_cache_top.sv
// top level of the arp neighbor cache: request launch, cell chain, commit and response
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_data (op, ip, mac, now)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_data (hit, mac, slot)
//  csr     | in / out  | psel, penable, pwrite  | paddr, pwdata, prdata
//
// an item passes from accept through the head register, then through the register of each cell
// as the probe walks the chain, then through the commit and response register
// one item is in the chain at a time; the next is accepted once the chain is empty
// and the skid register behind the response register is free
// a stalled response holds in the output register while one further item runs
// reset clears all valid bits, the victim pointer and the lifetime to 300000
`default_nettype none

module arp_neighbor_cache_top #(
   parameter int TABLE_ENTRIES = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  anc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output anc_pkg::rsp_type  rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire [2:0]         paddr,
   input  wire [31:0]        pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import anc_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   probe_type         chain_probe [0:TABLE_ENTRIES];
   logic [IDX_W-1:0]  chain_found [0:TABLE_ENTRIES];
   logic [IDX_W-1:0]  chain_free  [0:TABLE_ENTRIES];

   probe_type         head_ff, head_in;
   logic [31:0]       lifetime_ff, lifetime_in;
   logic [IDX_W-1:0]  victim_ff, victim_in;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              hold_valid_ff, hold_valid_in;
   rsp_type           hold_ff, hold_in;

   wr_type            wr;
   logic [IDX_W-1:0]  wr_slot;
   rsp_type           result;
   logic [IDX_W-1:0]  result_slot;
   logic [IDX_W+2:0]  result_slot_ext;
   logic [64:0]       expiry_sum;
   logic              req_xfer;
   logic              rsp_xfer;
   logic              csr_write;
   logic              done;
   probe_type         last;

   assign req_ready = !busy_ff && !hold_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_LIFETIME) ? lifetime_ff : 32'd0;

   assign expiry_sum = {1'b0, req_data.now_ms} + {33'd0, lifetime_ff};

   always_comb begin
      head_in            = head_ff;
      head_in.active     = req_xfer;
      if (req_xfer) begin
         head_in.op         = req_data.op;
         head_in.ip_addr    = req_data.ip_addr;
         head_in.mac_addr   = req_data.mac_addr;
         head_in.now_ms     = req_data.now_ms;
         head_in.expiry_new = expiry_sum[64] ? {64{1'b1}} : expiry_sum[63:0];
         head_in.found      = 1'b0;
         head_in.free_found = 1'b0;
      end
   end

   assign chain_probe[0] = head_ff;
   assign chain_found[0] = '0;
   assign chain_free[0]  = '0;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      anc_cell #(
         .IDX     (g),
         .IDX_W   (IDX_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .probe_i      (chain_probe[g]),
         .found_slot_i (chain_found[g]),
         .free_slot_i  (chain_free[g]),
         .probe_o      (chain_probe[g+1]),
         .found_slot_o (chain_found[g+1]),
         .free_slot_o  (chain_free[g+1]),
         .wr_i         (wr),
         .wr_slot_i    (wr_slot)
      );
   end

   assign last = chain_probe[TABLE_ENTRIES];
   assign done = last.active;

   always_comb begin
      wr          = '0;
      wr.ip_addr  = last.ip_addr;
      wr.mac_addr = last.mac_addr;
      wr.expiry   = last.expiry_new;
      wr_slot     = chain_found[TABLE_ENTRIES];
      victim_in   = victim_ff;
      result      = '0;
      result_slot = '0;
      if (done && (last.op == OP_INSERT)) begin
         wr.en = 1'b1;
         if (last.found) begin
            wr_slot = chain_found[TABLE_ENTRIES];
         end else if (last.free_found) begin
            wr.fill = 1'b1;
            wr_slot = chain_free[TABLE_ENTRIES];
         end else begin
            wr.fill   = 1'b1;
            wr_slot   = victim_ff;
            victim_in = (victim_ff == LAST_SLOT) ? '0 : victim_ff + 1'b1;
         end
         result.hit  = last.found;
         result_slot = wr_slot;
      end else if (last.found) begin
         result.hit       = 1'b1;
         result.mac_found = last.mac_addr;
         result_slot      = chain_found[TABLE_ENTRIES];
      end
      result_slot_ext  = {3'd0, result_slot};
      result.slot_used = result_slot_ext[2:0];
   end

   always_comb begin
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      lifetime_in   = lifetime_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
      if (rsp_xfer) begin
         rsp_valid_in = hold_valid_ff;
         rsp_in       = hold_ff;
         hold_valid_in = 1'b0;
      end
      if (done) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_in       = result;
         end else begin
            hold_valid_in = 1'b1;
            hold_in       = result;
         end
      end
      if (csr_write && (paddr[2] == REG_LIFETIME)) begin
         lifetime_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hold_valid_ff  <= 1'b0;
         victim_ff      <= '0;
         lifetime_ff    <= LIFETIME_RESET;
      end else begin
         head_ff        <= head_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
         hold_valid_ff  <= hold_valid_in;
         victim_ff      <= victim_in;
         lifetime_ff    <= lifetime_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff             <= rsp_in;
      hold_ff            <= hold_in;
   end

   logic [TABLE_ENTRIES:0] active_vec;
   for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_active
      assign active_vec[g] = chain_probe[g].active;
   end

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      $onehot0(active_vec))
      else $error("more than one probe in the chain");

   a_exit_while_busy : assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("probe left the chain with no item in flight");

   a_accept_starts_scan : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff && head_ff.active)
      else $error("accepted transfer did not enter the chain");

   a_hold_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

endmodule

`default_nettype wire

### sim/tb_arp_neighbor_cache_top.sv
// testbench for the arp neighbor cache: directed and random traffic against a local cache model
`timescale 1ns / 100ps

module tb_arp_neighbor_cache_top;
   import anc_pkg::*;

   localparam int ENTRIES        = 8;
   localparam int POOL_SIZE      = 12;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 40;
   localparam logic [2:0] LIFETIME_ADDR = {REG_LIFETIME, 2'b00};
   localparam logic [2:0] SPARE_ADDR    = {~REG_LIFETIME, 2'b00};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // local copy of the cache contents
   logic        tbl_valid [ENTRIES];
   logic [31:0] tbl_ip [ENTRIES];
   logic [47:0] tbl_mac [ENTRIES];
   logic [63:0] tbl_expiry [ENTRIES];
   int          tbl_victim;
   logic [31:0] tbl_lifetime;

   rsp_type     expected_answers [$];
   rsp_type     want_rsp;
   int          mismatches = 0;
   int          rsp_transfers = 0;
   int          idle_cycles = 0;
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   logic [31:0] ip_pool [POOL_SIZE];
   logic [63:0] cur_ms;

   arp_neighbor_cache_top #(
      .TABLE_ENTRIES(ENTRIES)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", what);
   endtask

   function automatic rsp_type resolve_neighbor(input req_type r);
      rsp_type     res;
      logic [64:0] sum;
      logic [63:0] expiry_new;
      logic        done;
      res  = '0;
      done = 1'b0;
      sum  = {1'b0, r.now_ms} + {33'd0, tbl_lifetime};
      expiry_new = sum[64] ? '1 : sum[63:0];
      if (r.op == OP_INSERT) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done && tbl_valid[i] && tbl_ip[i] == r.ip_addr) begin
               tbl_mac[i]    = r.mac_addr;
               tbl_expiry[i] = expiry_new;
               res.hit       = 1'b1;
               res.slot_used = i[2:0];
               done          = 1'b1;
            end
         end
         if (!done) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (!done && (!tbl_valid[i] || tbl_expiry[i] <= r.now_ms)) begin
                  res.slot_used = i[2:0];
                  done          = 1'b1;
               end
            end
            if (!done) begin
               res.slot_used = tbl_victim[2:0];
               tbl_victim    = (tbl_victim + 1) % ENTRIES;
            end
            tbl_valid[res.slot_used]  = 1'b1;
            tbl_ip[res.slot_used]     = r.ip_addr;
            tbl_mac[res.slot_used]    = r.mac_addr;
            tbl_expiry[res.slot_used] = expiry_new;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!done && tbl_valid[i]) begin
               if (tbl_expiry[i] <= r.now_ms) begin
                  tbl_valid[i] = 1'b0;
               end else if (tbl_ip[i] == r.ip_addr) begin
                  res.hit       = 1'b1;
                  res.mac_found = tbl_mac[i];
                  res.slot_used = i[2:0];
                  done          = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic req_type random_item(input int unsigned step_max);
      req_type     r;
      logic [63:0] wide;
      int unsigned pick;
      wide       = {$urandom(), $urandom()};
      r.mac_addr = wide[47:0];
      r.op       = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
      r.ip_addr  = ($urandom_range(0, 9) == 0) ? $urandom() :
                   ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         r.now_ms = {$urandom(), $urandom()};
      end else begin
         if (pick < 8) cur_ms = cur_ms - $urandom_range(0, step_max);
         else cur_ms = cur_ms + $urandom_range(0, step_max);
         r.now_ms = cur_ms;
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_req(input req_type item);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_answers.push_back(resolve_neighbor(item));
      @(negedge clock);
   endtask

   task automatic send_op(input logic op, input logic [31:0] ip, input logic [47:0] mac,
                          input logic [63:0] now);
      req_type r;
      r.op       = op;
      r.ip_addr  = ip;
      r.mac_addr = mac;
      r.now_ms   = now;
      send_req(r);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((addr >> 2) == REG_LIFETIME) tbl_lifetime = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_lifetime();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LIFETIME_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== tbl_lifetime)
         report_mismatch($sformatf("lifetime read %0d want %0d", prdata, tbl_lifetime));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_lifetime(input logic [31:0] value);
      settle();
      write_csr(LIFETIME_ADDR, value);
      check_lifetime();
   endtask

   task automatic test_csr_access();
      check_lifetime();
      write_csr(SPARE_ADDR, 32'd5);
      check_lifetime();
   endtask

   task automatic test_basic_mapping();
      send_op(OP_LOOKUP, 32'h0000_0000, 48'h0, 64'd0);
      send_op(OP_INSERT, 32'h0000_0000, 48'h0, 64'd0);
      send_op(OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'd1);
      send_op(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 64'd2);
      send_op(OP_INSERT, 32'h0000_0000, 48'h1234_5678_9ABC, 64'd3);
      send_op(OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 64'd4);
   endtask

   task automatic test_victim_wrap();
      for (int k = 2; k < ENTRIES; k++)
         send_op(OP_INSERT, 32'h0A00_0000 + k, 48'h0200_0000_0000 + k, 64'd10 + k);
      for (int k = 0; k <= ENTRIES; k++)
         send_op(OP_INSERT, 32'hC0A8_0100 + k, 48'h0400_0000_0000 + k, 64'd30 + k);
   endtask

   task automatic test_aging();
      set_lifetime(32'd10);
      send_op(OP_LOOKUP, 32'h0B00_0001, 48'h0, 64'd400000);
      send_op(OP_INSERT, 32'h0B00_000A, 48'hAAAA_0000_000A, 64'd400000);
      send_op(OP_INSERT, 32'h0B00_000B, 48'hAAAA_0000_000B, 64'd400001);
      // refresh of an entry that is still valid but already expired
      send_op(OP_INSERT, 32'h0B00_000A, 48'hAAAA_0000_00AA, 64'd400050);
      send_op(OP_INSERT, 32'h0B00_000C, 48'hAAAA_0000_000C, 64'd400055);
      send_op(OP_LOOKUP, 32'h0B00_000A, 48'h0, 64'd400060);
   endtask

   task automatic test_lifetime_extremes();
      set_lifetime(32'd0);
      send_op(OP_INSERT, 32'h0C00_000D, 48'h0000_0000_000D, 64'd7);
      send_op(OP_LOOKUP, 32'h0C00_000D, 48'h0, 64'd7);
      set_lifetime(32'hFFFF_FFFF);
      // expiry saturates at the top of the time range
      send_op(OP_INSERT, 32'h0C00_000E, 48'h0000_0000_000E, 64'hFFFF_FFFF_FFFF_FFF0);
      send_op(OP_LOOKUP, 32'h0C00_000E, 48'h0, 64'hFFFF_FFFF_FFFF_FFFE);
      send_op(OP_LOOKUP, 32'h0C00_000E, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
   endtask

   task automatic run_phase(input logic [31:0] lifetime, input int unsigned step_max,
                            input int count, input bit idle);
      set_lifetime(lifetime);
      idle_on = idle;
      foreach (ip_pool[k]) ip_pool[k] = $urandom();
      cur_ms = {16'd0, $urandom(), 16'd0};
      repeat (count) send_req(random_item(step_max));
   endtask

   task automatic test_random_traffic();
      run_phase(32'd40, 15, 240, 1'b1);
      run_phase(LIFETIME_RESET, 50000, 200, 1'b0);
      run_phase(32'd1, 2, 150, 1'b1);
      run_phase(32'hFFFF_FFFF, 32'h8000_0000, 190, 1'b1);
      run_phase($urandom_range(1, 1000), $urandom_range(1, 200), 210, 1'b1);
   endtask

   task automatic test_backpressure();
      set_lifetime(32'd25);
      idle_on      = 1'b0;
      hold_request = 1'b1;
      repeat (24) send_req(random_item(8));
      settle();
      idle_on = 1'b1;
   endtask

   initial begin : rsp_side
      int unsigned gap;
      int          seen;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         gap = idle_on ? $urandom_range(0, 4) : 0;
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         seen = rsp_transfers;
         rsp_ready <= 1'b1;
         do @(negedge clock); while (rsp_transfers == seen && !hold_request);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_transfers++;
         if (expected_answers.size() == 0) begin
            report_mismatch("result transfer with nothing outstanding");
         end else begin
            want_rsp = expected_answers.pop_front();
            if (rsp_data.hit !== want_rsp.hit)
               report_mismatch($sformatf("hit got %b want %b", rsp_data.hit, want_rsp.hit));
            if (rsp_data.mac_found !== want_rsp.mac_found)
               report_mismatch($sformatf("mac_found got %h want %h",
                                         rsp_data.mac_found, want_rsp.mac_found));
            if (rsp_data.slot_used !== want_rsp.slot_used)
               report_mismatch($sformatf("slot_used got %0d want %0d",
                                         rsp_data.slot_used, want_rsp.slot_used));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      tbl_victim   = 0;
      tbl_lifetime = LIFETIME_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_csr_access();
      test_basic_mapping();
      test_victim_wrap();
      test_aging();
      test_lifetime_extremes();
      test_random_traffic();
      test_backpressure();

      settle();
      repeat (3 * ENTRIES) @(negedge clock);
      if (expected_answers.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/anc_pkg.sv
rtl/anc_cell.sv
rtl/arp_neighbor_cache_top.sv
sim/tb_arp_neighbor_cache_top.sv
